// ===== src/lkvt_pkg.sv =====
// Shared constants, codes and control types for the linear key-value table.
// Used by lkvt_ctrl, lkvt_dp and the top level linear_key_value_table.
package lkvt_pkg;

	// Table geometry and field widths
	localparam int TABLE_DEPTH = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Request operation codes
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_VREAD,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture request, restart the scan
		logic scan_en;  // issue key reads and compare
		logic vread;    // read value of the matched entry
		logic commit;   // apply update, load output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic  done;    // scan finished (hit or all entries compared)
		logic  hit;     // key matched an entry
		mode_t mode;    // operation of the current item
	} dp_sts_t;

endpackage

// ===== src/linear_key_value_table.sv =====
// Linear key-value table of up to 16 entries with insert, lookup, remove
// newest and clear operations.
//
// Input channel (in_valid/in_stall): mode, key, value. An item is taken
// when in_valid is high and in_stall low. One item is in work at a time;
// in_stall is high from acceptance until its result is committed.
// Output channel (out_valid/out_stall): found, position, value_out, count,
// empty_res, status, one result per item, held in an output register.
// Insert and lookup scan the filled entries for the key, at most 16
// (none when the table is empty); a lookup hit adds a read of the
// value. Remove and clear skip the scan and go straight to the commit.
// The next item is taken the cycle after the commit, so with no output
// stall the key scan sets the rate of items.
// A stalled result stays on the output; the next item may be accepted and
// searched meanwhile, and waits for the output register to free up.
// Reset (arst_n low) empties the table and drops any pending result;
// entry contents are not cleared.
// Depends on lkvt_pkg, lkvt_ctrl and lkvt_dp.
module linear_key_value_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic [lkvt_pkg::KEY_W-1:0]      key,
	input  logic [lkvt_pkg::VAL_W-1:0]      value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [lkvt_pkg::IDX_W-1:0]      position,
	output logic [lkvt_pkg::VAL_W-1:0]      value_out,
	output logic [lkvt_pkg::CNT_W-1:0]      count,
	output logic                            empty_res,
	output logic [1:0]                      status
);

	lkvt_pkg::dp_cmd_t cmd;
	lkvt_pkg::dp_sts_t sts;

	// Sequencer
	lkvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_mode   (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Storage, scan and result datapath
	lkvt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mode      (mode),
		.key       (key),
		.value     (value),
		.found     (found),
		.position  (position),
		.value_out (value_out),
		.count     (count),
		.empty_res (empty_res),
		.status    (status)
	);

endmodule

// ===== src/lkvt_dp.sv =====
// Datapath of the key-value table: request registers, key/value memories,
// pipelined linear key scan, update logic and the output register.
// Depends on lkvt_pkg.
module lkvt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lkvt_pkg::dp_cmd_t               cmd,
	output lkvt_pkg::dp_sts_t               sts,
	input  logic [1:0]                      mode,
	input  logic [lkvt_pkg::KEY_W-1:0]      key,
	input  logic [lkvt_pkg::VAL_W-1:0]      value,
	output logic                            found,
	output logic [lkvt_pkg::IDX_W-1:0]      position,
	output logic [lkvt_pkg::VAL_W-1:0]      value_out,
	output logic [lkvt_pkg::CNT_W-1:0]      count,
	output logic                            empty_res,
	output logic [1:0]                      status
);

	// Entry storage, read data registered
	logic [lkvt_pkg::KEY_W-1:0] key_mem [lkvt_pkg::TABLE_DEPTH];
	logic [lkvt_pkg::VAL_W-1:0] val_mem [lkvt_pkg::TABLE_DEPTH];

	lkvt_pkg::mode_t             mode_q;
	logic [lkvt_pkg::KEY_W-1:0]  key_q;
	logic [lkvt_pkg::VAL_W-1:0]  val_q;
	logic [lkvt_pkg::CNT_W-1:0]  count_q;

	logic [lkvt_pkg::CNT_W-1:0]  scan_q;
	logic                        rd_vld_s1;
	logic [lkvt_pkg::KEY_W-1:0]  rd_key_s1;
	logic [lkvt_pkg::IDX_W-1:0]  rd_idx_s1;
	logic                        hit_q;
	logic [lkvt_pkg::IDX_W-1:0]  hit_idx_q;
	logic [lkvt_pkg::VAL_W-1:0]  vrd_q;

	logic                        issue;
	logic                        match;

	logic                        res_found;
	logic [lkvt_pkg::IDX_W-1:0]  res_pos;
	logic [lkvt_pkg::VAL_W-1:0]  res_vout;
	lkvt_pkg::status_t           res_stat;
	logic [lkvt_pkg::CNT_W-1:0]  cnt_nxt;
	logic                        wr_key_en;
	logic                        wr_val_en;
	logic [lkvt_pkg::IDX_W-1:0]  wr_addr;

	logic                        found_q;
	logic [lkvt_pkg::IDX_W-1:0]  pos_q;
	logic [lkvt_pkg::VAL_W-1:0]  vout_q;
	logic [lkvt_pkg::CNT_W-1:0]  cnt_out_q;
	logic                        empty_q;
	lkvt_pkg::status_t           stat_q;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= lkvt_pkg::mode_t'(mode);
			key_q  <= key;
			val_q  <= value;
		end
	end

	// Scan: one read issued per cycle, compared in the next cycle on the registered read data
	assign issue = cmd.scan_en && (scan_q < count_q) && !hit_q;
	assign match = rd_vld_s1 && (rd_key_s1 == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.load) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + lkvt_pkg::CNT_W'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_key_s1 <= key_mem[scan_q[lkvt_pkg::IDX_W-1:0]];
			rd_idx_s1 <= scan_q[lkvt_pkg::IDX_W-1:0];
		end
		if (match && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cmd.vread) begin
			vrd_q <= val_mem[hit_idx_q];
		end
	end

	assign sts.hit  = hit_q;
	assign sts.done = hit_q || ((scan_q >= count_q) && !rd_vld_s1);
	assign sts.mode = mode_q;

	// Result and update for the current operation
	always_comb begin
		res_found = 1'b0;
		res_pos   = '0;
		res_vout  = '0;
		res_stat  = lkvt_pkg::STAT_OK;
		cnt_nxt   = count_q;
		wr_key_en = 1'b0;
		wr_val_en = 1'b0;
		wr_addr   = hit_q ? hit_idx_q : count_q[lkvt_pkg::IDX_W-1:0];
		unique case (mode_q)
			lkvt_pkg::MODE_INSERT: begin
				if (hit_q) begin
					res_found = 1'b1;
					res_pos   = hit_idx_q;
					wr_val_en = 1'b1;
				end else if (count_q < lkvt_pkg::CNT_W'(lkvt_pkg::TABLE_DEPTH)) begin
					res_pos   = count_q[lkvt_pkg::IDX_W-1:0];
					wr_key_en = 1'b1;
					wr_val_en = 1'b1;
					cnt_nxt   = count_q + lkvt_pkg::CNT_W'(1);
				end else begin
					res_stat = lkvt_pkg::STAT_FULL;
				end
			end
			lkvt_pkg::MODE_LOOKUP: begin
				if (hit_q) begin
					res_found = 1'b1;
					res_pos   = hit_idx_q;
					res_vout  = vrd_q;
				end
			end
			lkvt_pkg::MODE_REMOVE: begin
				if (count_q != '0) begin
					cnt_nxt = count_q - lkvt_pkg::CNT_W'(1);
				end else begin
					res_stat = lkvt_pkg::STAT_EMPTY;
				end
			end
			lkvt_pkg::MODE_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = count_q;
			end
		endcase
	end

	// Entry writes on commit
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_key_en) begin
			key_mem[wr_addr] <= key_q;
		end
		if (cmd.commit && wr_val_en) begin
			val_mem[wr_addr] <= val_q;
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= cnt_nxt;
		end
	end

	// Output register, held until the item is taken
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q   <= res_found;
			pos_q     <= res_pos;
			vout_q    <= res_vout;
			cnt_out_q <= cnt_nxt;
			empty_q   <= (cnt_nxt == '0);
			stat_q    <= res_stat;
		end
	end

	assign found     = found_q;
	assign position  = pos_q;
	assign value_out = vout_q;
	assign count     = cnt_out_q;
	assign empty_res = empty_q;
	assign status    = stat_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lkvt_pkg::CNT_W'(lkvt_pkg::TABLE_DEPTH))
		else $error("fill count above table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (rd_vld_s1 && (lkvt_pkg::CNT_W'(rd_idx_s1) < count_q)))
		else $error("key read beyond filled entries");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && !cmd.commit) |-> (lkvt_pkg::CNT_W'(hit_idx_q) < count_q))
		else $error("matched index outside filled entries");

endmodule

// ===== src/lkvt_ctrl.sv =====
// Controller state machine of the key-value table: accepts items, runs the
// key scan, the value read and the commit into the output register.
// Depends on lkvt_pkg.
module lkvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        in_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output lkvt_pkg::dp_cmd_t cmd,
	input  lkvt_pkg::dp_sts_t sts
);

	lkvt_pkg::state_t state_q;
	lkvt_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             needs_scan;

	assign needs_scan = (in_mode == lkvt_pkg::MODE_INSERT) ||
		(in_mode == lkvt_pkg::MODE_LOOKUP);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		unique case (state_q)
			lkvt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = needs_scan ? lkvt_pkg::ST_SEARCH : lkvt_pkg::ST_FINISH;
				end
			end
			lkvt_pkg::ST_SEARCH: begin
				cmd.scan_en = 1'b1;
				if (sts.done) begin
					state_nxt = (sts.hit && (sts.mode == lkvt_pkg::MODE_LOOKUP)) ?
						lkvt_pkg::ST_VREAD : lkvt_pkg::ST_FINISH;
				end
			end
			lkvt_pkg::ST_VREAD: begin
				cmd.vread = 1'b1;
				state_nxt = lkvt_pkg::ST_FINISH;
			end
			lkvt_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_nxt  = lkvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lkvt_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid: set on commit, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != lkvt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Checks
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit overwrote a pending result");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_vread_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkvt_pkg::ST_VREAD) |-> (sts.hit && (sts.mode == lkvt_pkg::MODE_LOOKUP)))
		else $error("value read without a lookup hit");

endmodule

// ===== tb/lkvt_checker.sv =====
// Checker for the linear key-value table: watches both channels, keeps a
// shadow table, predicts one reply per request and compares field by field.
// Depends on lkvt_pkg.
module lkvt_checker
	import lkvt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       mode,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             found,
	input  logic [IDX_W-1:0] position,
	input  logic [VAL_W-1:0] value_out,
	input  logic [CNT_W-1:0] count,
	input  logic             empty_res,
	input  logic [1:0]       status,
	output int               fail_count,
	output int               pending,
	output int               checked,
	output int               hit_count,
	output int               full_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] count;
		logic             empty_res;
		status_t          status;
	} table_reply_t;

	// shadow of the table contents and fill count
	logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	logic [VAL_W-1:0] shadow_vals [TABLE_DEPTH];
	int               fill;

	// predicted replies, oldest first
	table_reply_t predicted_replies [$];

	initial begin
		fill = 0;
		fail_count = 0;
		pending = 0;
		checked = 0;
		hit_count = 0;
		full_count = 0;
	end

	// apply one request to the shadow table and return its reply
	function automatic table_reply_t apply_table_op(mode_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		table_reply_t r;
		int slot;
		r = '0;
		r.status = STAT_OK;
		slot = -1;
		// linear search, lowest index wins
		if (op == MODE_INSERT || op == MODE_LOOKUP) begin
			for (int i = 0; i < fill; i++) begin
				if (slot < 0 && shadow_keys[i] == k) begin
					slot = i;
				end
			end
		end
		case (op)
			MODE_INSERT: begin
				if (slot >= 0) begin
					shadow_vals[slot] = v;
					r.found = 1'b1;
					r.position = IDX_W'(slot);
				end else if (fill < TABLE_DEPTH) begin
					shadow_keys[fill] = k;
					shadow_vals[fill] = v;
					r.position = IDX_W'(fill);
					fill++;
				end else begin
					r.status = STAT_FULL;
				end
			end
			MODE_LOOKUP: begin
				if (slot >= 0) begin
					r.found = 1'b1;
					r.position = IDX_W'(slot);
					r.value_out = shadow_vals[slot];
				end
			end
			MODE_REMOVE: begin
				if (fill > 0) begin
					fill--;
				end else begin
					r.status = STAT_EMPTY;
				end
			end
			default: begin
				fill = 0;
			end
		endcase
		r.count = CNT_W'(fill);
		r.empty_res = (fill == 0);
		return r;
	endfunction

	// compare the reply on the output ports against a prediction
	task automatic check_reply(input table_reply_t want);
		int bad;
		bad = 0;
		if (found !== want.found) begin
			$error("found mismatch: expected %0d, got %0d", want.found, found);
			bad = 1;
		end
		if (position !== want.position) begin
			$error("position mismatch: expected %0d, got %0d", want.position, position);
			bad = 1;
		end
		if (value_out !== want.value_out) begin
			$error("value_out mismatch: expected %h, got %h", want.value_out, value_out);
			bad = 1;
		end
		if (count !== want.count) begin
			$error("count mismatch: expected %0d, got %0d", want.count, count);
			bad = 1;
		end
		if (empty_res !== want.empty_res) begin
			$error("empty_res mismatch: expected %0d, got %0d", want.empty_res, empty_res);
			bad = 1;
		end
		if (status !== want.status) begin
			$error("status mismatch: expected %0d, got %0d", want.status, status);
			bad = 1;
		end
		fail_count += bad;
	endtask

	// reply side first, so a same-edge request never pairs with its own reply
	always @(posedge clk or negedge arst_n) begin : watch
		table_reply_t want;
		if (!arst_n) begin
			fill = 0;
			predicted_replies.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					$error("reply with no request outstanding");
					fail_count++;
				end else begin
					want = predicted_replies.pop_front();
					check_reply(want);
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_table_op(mode_t'(mode), key, value);
				if (want.found) hit_count++;
				if (want.status == STAT_FULL) full_count++;
				predicted_replies.push_back(want);
			end
		end
		pending = predicted_replies.size();
	end

endmodule

// ===== tb/tb_linear_key_value_table.sv =====
// Testbench top for linear_key_value_table: clock, reset, request stimulus,
// random reply stalls and the final verdict.
// Depends on lkvt_pkg, linear_key_value_table and lkvt_checker.
module tb_linear_key_value_table;
	timeunit 1ns;
	timeprecision 1ps;
	import lkvt_pkg::*;

	localparam int RANDOM_ITEMS = 1424;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       mode;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [IDX_W-1:0] position;
	logic [VAL_W-1:0] value_out;
	logic [CNT_W-1:0] count;
	logic             empty_res;
	logic [1:0]       status;

	int fail_count;
	int pending;
	int checked;
	int hit_count;
	int full_count;
	int cycle_cnt;
	int mode_tally [4];
	bit quiet;

	// most recent 40 keys inserted, used to aim lookups and updates at stored entries
	logic [KEY_W-1:0] key_pool [$];

	linear_key_value_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.position  (position),
		.value_out (value_out),
		.count     (count),
		.empty_res (empty_res),
		.status    (status)
	);

	lkvt_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.position   (position),
		.value_out  (value_out),
		.count      (count),
		.empty_res  (empty_res),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.hit_count  (hit_count),
		.full_count (full_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("linear_key_value_table regression: fail");
		$finish;
	end

	// reply side stalls in random bursts, none while quiet
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// mostly wide random keys, some corner values and a few small ones
	function automatic logic [KEY_W-1:0] fresh_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return KEY_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] known_key();
		if (key_pool.size() == 0) return fresh_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// one request: optional idle burst, then hold until accepted
	task automatic send_item(input mode_t op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		key <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mode_tally[int'(op)]++;
		if (op == MODE_INSERT) begin
			key_pool.push_back(k);
			if (key_pool.size() > 40) void'(key_pool.pop_front());
		end
	endtask

	// stop sending until every reply has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int phase;
		int roll;
		mode_t op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;

		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		key = '0;
		value = '0;
		out_stall = 1'b0;
		quiet = 1'b0;
		foreach (mode_tally[i]) mode_tally[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, key zero against the not-found index,
		// update in place, fill to the top, full insert, remove and clear
		send_item(MODE_REMOVE, '0, '0);
		send_item(MODE_LOOKUP, '0, '0);
		send_item(MODE_INSERT, '0, '1);
		send_item(MODE_LOOKUP, '0, '0);
		send_item(MODE_INSERT, '1, '0);
		send_item(MODE_INSERT, '0, 32'h5a5a_a5a5);
		for (int i = 1; i <= 14; i++) begin
			send_item(MODE_INSERT, i * 32'h1111_1111, ~(i * 32'h1111_1111));
		end
		send_item(MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
		send_item(MODE_INSERT, 32'heeee_eeee, 32'hdead_beef);
		send_item(MODE_LOOKUP, 32'heeee_eeee, '0);
		send_item(MODE_REMOVE, '1, '1);
		send_item(MODE_LOOKUP, 32'heeee_eeee, '0);
		send_item(MODE_CLEAR, '1, '1);
		send_item(MODE_LOOKUP, '0, '0);
		wait_drained();

		// random: phases lean toward filling, mixing or draining the table
		phase = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) phase = $urandom_range(0, 2);
			quiet = (n >= 600 && n < 700) || (n >= RANDOM_ITEMS - 150);
			if (n == 400) wait_drained();
			roll = $urandom_range(0, 99);
			case (phase)
				0: op = roll < 70 ? MODE_INSERT : roll < 90 ? MODE_LOOKUP :
					roll < 98 ? MODE_REMOVE : MODE_CLEAR;
				1: op = roll < 35 ? MODE_INSERT : roll < 75 ? MODE_LOOKUP :
					roll < 95 ? MODE_REMOVE : MODE_CLEAR;
				default: op = roll < 20 ? MODE_INSERT : roll < 50 ? MODE_LOOKUP :
					roll < 95 ? MODE_REMOVE : MODE_CLEAR;
			endcase
			case (op)
				MODE_INSERT: k = $urandom_range(0, 1) ? known_key() : fresh_key();
				MODE_LOOKUP: k = $urandom_range(0, 3) != 0 ? known_key() : fresh_key();
				default: k = $urandom;
			endcase
			// noise: any operation with any key
			if ($urandom_range(0, 9) == 0) begin
				op = mode_t'($urandom_range(0, 3));
				k = fresh_key();
			end
			case ($urandom_range(0, 15))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			send_item(op, k, v);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("requests sent: %0d inserts, %0d lookups, %0d removes, %0d clears",
			mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3]);
		$display("replies checked: %0d, key hits: %0d, inserts refused when full: %0d",
			checked, hit_count, full_count);
		if (fail_count == 0 && pending == 0) begin
			$display("linear_key_value_table regression: pass");
		end else begin
			$display("linear_key_value_table regression: fail");
		end
		$finish;
	end

endmodule
